FILE: hdl/pdsc_pkg.sv
package pdsc_pkg;

   // default size of the power data area in bytes (header plus objects)
   localparam int AREA_BYTES_DEFAULT = 48;

   localparam int DATA_W    = 8;
   localparam int COUNT_W   = 3;
   localparam int FIELD_W   = 10;
   localparam int VSEL_W    = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // pdo supply type codes, bits 31:30
   localparam logic [1:0] SUPPLY_FIXED     = 2'b00;
   localparam logic [1:0] SUPPLY_AUGMENTED = 2'b11;
   // augmented subtype, bits 29:28
   localparam logic [1:0] AUG_PPS          = 2'b00;

   // register index, taken from paddr bit 2
   typedef enum logic {
      REG_VOLTAGE_SELECT = 1'b0,
      REG_PPS_SUPPORTED  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [DATA_W-1:0] data_byte;
      logic              first_byte;
      logic              last_byte;
   } req_type;

   typedef struct packed {
      logic               message_valid;
      logic [COUNT_W-1:0] object_count;
      logic               fixed_found;
      logic [FIELD_W-1:0] fixed_current;
      logic               pps_found;
   } rsp_type;

   typedef struct packed {
      logic [VSEL_W-1:0] voltage_select;
      logic              pps_supported;
   } cfg_type;

   // target voltage in 50 mV units; codes 6 and 7 select nothing
   function automatic logic [FIELD_W:0] target_units(input logic [VSEL_W-1:0] sel);
      logic [FIELD_W:0] result;
      begin
         case (sel)
            3'd0: result = {1'b1, 10'd100};
            3'd1: result = {1'b1, 10'd180};
            3'd2: result = {1'b1, 10'd240};
            3'd3: result = {1'b1, 10'd300};
            3'd4: result = {1'b1, 10'd400};
            3'd5: result = {1'b1, 10'd560};
            default: result = '0;
         endcase
         return result;
      end
   endfunction

endpackage

FILE: hdl/pdsc_csr.sv
module pdsc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [pdsc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [pdsc_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [pdsc_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output pdsc_pkg::cfg_type                cfg
);
   import pdsc_pkg::*;

   logic [VSEL_W-1:0] voltage_select_ff, voltage_select_in;
   logic              pps_supported_ff, pps_supported_in;
   logic              write_en;
   csr_index_type     index;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel & csr_penable & csr_pwrite;
   assign index      = csr_index_type'(csr_paddr[2]);

   always_comb begin
      voltage_select_in = voltage_select_ff;
      pps_supported_in  = pps_supported_ff;
      if (write_en) begin
         case (index)
            REG_VOLTAGE_SELECT: voltage_select_in = csr_pwdata[VSEL_W-1:0];
            REG_PPS_SUPPORTED:  pps_supported_in  = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_VOLTAGE_SELECT: csr_prdata = CSR_DATA_W'(voltage_select_ff);
         REG_PPS_SUPPORTED:  csr_prdata = CSR_DATA_W'(pps_supported_ff);
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         voltage_select_ff <= '0;
         pps_supported_ff  <= 1'b1;
      end else begin
         voltage_select_ff <= voltage_select_in;
         pps_supported_ff  <= pps_supported_in;
      end
   end

   assign cfg.voltage_select = voltage_select_ff;
   assign cfg.pps_supported  = pps_supported_ff;

endmodule

FILE: hdl/pdsc_scan.sv
module pdsc_scan #(
   parameter int AREA_BYTES = pdsc_pkg::AREA_BYTES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  pdsc_pkg::req_type item,
   input  pdsc_pkg::cfg_type cfg,
   output pdsc_pkg::rsp_type result
);
   import pdsc_pkg::*;

   localparam int PosW = $clog2(AREA_BYTES + 1);

   logic [PosW-1:0]    byte_position_ff, byte_position_in;
   logic [COUNT_W-1:0] count_held_ff, count_held_in;
   logic [23:0]        word_bytes_ff, word_bytes_in;
   logic               match_seen_ff, match_seen_in;
   logic [FIELD_W-1:0] match_current_ff, match_current_in;
   logic               pps_seen_ff, pps_seen_in;

   // scan state as seen by this byte, after a restart if marked first
   logic [PosW-1:0]    pos;
   logic [COUNT_W-1:0] count_cur;
   logic               match_cur;
   logic [FIELD_W-1:0] current_cur;
   logic               pps_cur;
   logic [PosW-1:0]    offset;
   logic [1:0]         lane;
   logic [PosW-1:0]    index;
   logic [1:0]         supply;
   logic [FIELD_W:0]   target;
   logic               fits;

   always_comb begin
      pos         = item.first_byte ? '0 : byte_position_ff;
      count_cur   = item.first_byte ? '0 : count_held_ff;
      match_cur   = item.first_byte ? 1'b0 : match_seen_ff;
      current_cur = item.first_byte ? '0 : match_current_ff;
      pps_cur     = item.first_byte ? 1'b0 : pps_seen_ff;

      offset = pos - PosW'(2);
      lane   = offset[1:0];
      index  = offset >> 2;
      supply = item.data_byte[7:6];
      target = target_units(cfg.voltage_select);

      byte_position_in = pos;
      count_held_in    = count_cur;
      word_bytes_in    = item.first_byte ? '0 : word_bytes_ff;
      match_seen_in    = match_cur;
      match_current_in = current_cur;
      pps_seen_in      = pps_cur;

      if (pos < PosW'(AREA_BYTES)) begin
         byte_position_in = pos + PosW'(1);
         if (pos == PosW'(0)) begin
            // header low byte carries nothing used here
         end else if (pos == PosW'(1)) begin
            count_held_in = item.data_byte[6:4];
         end else begin
            case (lane)
               2'd0: word_bytes_in = {16'h0000, item.data_byte};
               2'd1: word_bytes_in[15:8]  = item.data_byte;
               2'd2: word_bytes_in[23:16] = item.data_byte;
               default: begin
                  // top byte completes the object; judge it if within count
                  if (index < PosW'(count_cur)) begin
                     if (supply == SUPPLY_FIXED) begin
                        if (!match_cur && target[FIELD_W] &&
                            word_bytes_ff[19:10] == target[FIELD_W-1:0]) begin
                           match_seen_in    = 1'b1;
                           match_current_in = word_bytes_ff[FIELD_W-1:0];
                        end
                     end else if (supply == SUPPLY_AUGMENTED &&
                                  item.data_byte[5:4] == AUG_PPS) begin
                        pps_seen_in = 1'b1;
                     end
                  end
               end
            endcase
         end
      end

      fits = (count_held_in != '0) &&
             (7'({count_held_in, 2'b10}) <= 7'(AREA_BYTES));

      result.message_valid = fits;
      result.object_count  = count_held_in;
      result.fixed_found   = fits & match_seen_in;
      result.fixed_current = (fits & match_seen_in) ? match_current_in : '0;
      result.pps_found     = fits & pps_seen_in & cfg.pps_supported;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff <= '0;
         count_held_ff    <= '0;
         word_bytes_ff    <= '0;
         match_seen_ff    <= 1'b0;
         match_current_ff <= '0;
         pps_seen_ff      <= 1'b0;
      end else if (take) begin
         byte_position_ff <= byte_position_in;
         count_held_ff    <= count_held_in;
         word_bytes_ff    <= word_bytes_in;
         match_seen_ff    <= match_seen_in;
         match_current_ff <= match_current_in;
         pps_seen_ff      <= pps_seen_in;
      end
   end

endmodule

FILE: hdl/pdsc_out.sv
module pdsc_out (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  pdsc_pkg::rsp_type result,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output pdsc_pkg::rsp_type rsp_payload,
   output logic              blocked
);
   import pdsc_pkg::*;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_payload_ff, rsp_payload_in;

   // held result not yet taken: no new byte may enter
   assign blocked = rsp_valid_ff & rsp_stall;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      if (load) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

FILE: hdl/pd_source_caps_scanner_unit.sv
// usb pd source caps scanner: takes a message one byte per transaction
// (16-bit little-endian header, then 32-bit little-endian power data objects)
// and on the byte marked last gives one result: object count from header bits
// 14:12, whether the count is nonzero and fits the area, the 10 mA current of
// the first fixed object at the selected voltage, and whether a pps object was
// seen. a byte marked first restarts the scan; bytes beyond AREA_BYTES change
// nothing. one byte is accepted every cycle, and the result appears on rsp_* in
// the cycle after the last byte is accepted; the only thing that holds the input
// back is a result register that is full and stalled. registers: voltage_select at
// byte address 0 (codes 0..5 = 5, 9, 12, 15, 20, 28 v), pps_supported at 4
// (reset 1); write them only while no message is in flight.
module pd_source_caps_scanner_unit #(
   parameter int AREA_BYTES = pdsc_pkg::AREA_BYTES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // byte input
   input  logic                            req_valid,
   output logic                            req_stall,
   input  pdsc_pkg::req_type               req_payload,
   // result output
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output pdsc_pkg::rsp_type               rsp_payload,
   // register port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [pdsc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [pdsc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [pdsc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import pdsc_pkg::*;

   cfg_type cfg;
   rsp_type result;
   logic    take;
   logic    blocked;

   // a transaction on the input channel
   assign req_stall = blocked;
   assign take      = req_valid & ~blocked;

   pdsc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // scan state and the per-byte logic that also forms the result
   pdsc_scan #(
      .AREA_BYTES (AREA_BYTES)
   ) u_scan (
      .clock  (clock),
      .reset  (reset),
      .take   (take),
      .item   (req_payload),
      .cfg    (cfg),
      .result (result)
   );

   // result register, loaded only on the byte marked last
   pdsc_out u_out (
      .clock       (clock),
      .reset       (reset),
      .load        (take & req_payload.last_byte),
      .result      (result),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .blocked     (blocked)
   );

endmodule

FILE: sim/tb_pd_source_caps_scanner_unit.sv
`timescale 1ns / 100ps

module tb_pd_source_caps_scanner_unit;

   import pdsc_pkg::*;

   // power data area of the instance under test (default size)
   localparam int AREA = AREA_BYTES_DEFAULT;

   // voltage select codes, 50 mV targets in the comments
   localparam logic [2:0] VSEL_5V    = 3'd0;   // 100
   localparam logic [2:0] VSEL_9V    = 3'd1;   // 180
   localparam logic [2:0] VSEL_12V   = 3'd2;   // 240
   localparam logic [2:0] VSEL_15V   = 3'd3;   // 300
   localparam logic [2:0] VSEL_20V   = 3'd4;   // 400
   localparam logic [2:0] VSEL_28V   = 3'd5;   // 560
   localparam logic [2:0] VSEL_NONE6 = 3'd6;   // unused code, selects nothing
   localparam logic [2:0] VSEL_NONE7 = 3'd7;   // unused code, selects nothing

   typedef logic [7:0] octet_queue_type[$];

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #4 clock = ~clock;

   // byte channel
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;

   // result channel
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   // register port
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   pd_source_caps_scanner_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // scan results still owed by the block, oldest first
   rsp_type caps_expected[$];

   int unsigned error_count = 0;
   int unsigned caps_seen   = 0;
   int unsigned items_sent  = 0;
   int unsigned burst_left  = 0;

   // predictor copy of the registers (reset values)
   logic [2:0] cfg_vsel = VSEL_5V;
   logic       cfg_pps  = 1'b1;

   // predictor copy of the scan state
   int unsigned scan_pos   = 0;
   logic [2:0]  scan_count = '0;
   logic [23:0] word_low   = '0;
   logic        scan_match = 1'b0;
   logic [9:0]  match_cur  = '0;
   logic        scan_pps   = 1'b0;

   task automatic report_error(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   // ---------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------

   // 50 mV target for a select code, top bit says whether the code selects one
   function automatic logic [10:0] target_for(logic [2:0] sel);
      case (sel)
         VSEL_5V:  return {1'b1, 10'd100};
         VSEL_9V:  return {1'b1, 10'd180};
         VSEL_12V: return {1'b1, 10'd240};
         VSEL_15V: return {1'b1, 10'd300};
         VSEL_20V: return {1'b1, 10'd400};
         VSEL_28V: return {1'b1, 10'd560};
         default:  return '0;
      endcase
   endfunction

   function automatic void clear_scan();
      scan_pos   = 0;
      scan_count = '0;
      word_low   = '0;
      scan_match = 1'b0;
      match_cur  = '0;
      scan_pps   = 1'b0;
   endfunction

   // one complete power data object inside the count
   function automatic void judge_object(logic [31:0] pdo);
      logic [10:0] target;
      target = target_for(cfg_vsel);
      if (pdo[31:30] == SUPPLY_FIXED) begin
         // only the first match counts
         if (!scan_match && target[10] && pdo[19:10] == target[9:0]) begin
            scan_match = 1'b1;
            match_cur  = pdo[9:0];
         end
      end else if (pdo[31:30] == SUPPLY_AUGMENTED && pdo[29:28] == AUG_PPS) begin
         scan_pps = 1'b1;
      end
   endfunction

   // takes one accepted byte, gives 1 with the result when the byte ends a message
   function automatic bit scan_byte(req_type item, output rsp_type res);
      int unsigned idx;
      int unsigned lane;
      logic        fits;
      res = '0;
      if (item.first_byte)
         clear_scan();
      // bytes past the area leave the state alone
      if (scan_pos < AREA) begin
         if (scan_pos == 1) begin
            scan_count = item.data_byte[6:4];
         end else if (scan_pos >= 2) begin
            idx  = (scan_pos - 2) >> 2;
            lane = (scan_pos - 2) & 3;
            case (lane)
               0: word_low = {16'h0000, item.data_byte};
               1: word_low[15:8] = item.data_byte;
               2: word_low[23:16] = item.data_byte;
               default: begin
                  // objects beyond the header count are not judged
                  if (idx < scan_count)
                     judge_object({item.data_byte, word_low});
               end
            endcase
         end
         scan_pos++;
      end
      if (!item.last_byte)
         return 1'b0;
      fits = (scan_count != 0) && (2 + 4 * scan_count <= AREA);
      res.message_valid = fits;
      res.object_count  = scan_count;
      res.fixed_found   = fits && scan_match;
      res.fixed_current = (fits && scan_match) ? match_cur : 10'd0;
      res.pps_found     = fits && scan_pps && cfg_pps;
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------
   // result checker: every accepted result against the oldest prediction
   // ---------------------------------------------------------------
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (caps_expected.size() == 0) begin
            report_error($sformatf("result %0d arrived with none expected", caps_seen));
         end else begin
            want = caps_expected.pop_front();
            if (rsp_payload.message_valid !== want.message_valid)
               report_error($sformatf("result %0d message_valid: expected %0b got %0b",
                  caps_seen, want.message_valid, rsp_payload.message_valid));
            if (rsp_payload.object_count !== want.object_count)
               report_error($sformatf("result %0d object_count: expected %0d got %0d",
                  caps_seen, want.object_count, rsp_payload.object_count));
            if (rsp_payload.fixed_found !== want.fixed_found)
               report_error($sformatf("result %0d fixed_found: expected %0b got %0b",
                  caps_seen, want.fixed_found, rsp_payload.fixed_found));
            if (rsp_payload.fixed_current !== want.fixed_current)
               report_error($sformatf("result %0d fixed_current: expected %0d got %0d",
                  caps_seen, want.fixed_current, rsp_payload.fixed_current));
            if (rsp_payload.pps_found !== want.pps_found)
               report_error($sformatf("result %0d pps_found: expected %0b got %0b",
                  caps_seen, want.pps_found, rsp_payload.pps_found));
         end
         caps_seen++;
      end
   end

   // ---------------------------------------------------------------
   // receiver back-pressure: alternating runs of free and stalled cycles,
   // free runs longer so that quiet stretches appear as well
   // ---------------------------------------------------------------
   int unsigned stall_run  = 0;
   logic        stall_hold = 1'b0;

   always @(posedge clock) begin
      if (stall_run == 0) begin
         stall_hold = ($urandom_range(0, 3) == 0);
         stall_run  = stall_hold ? $urandom_range(1, 6) : $urandom_range(1, 24);
      end
      stall_run--;
      rsp_stall <= stall_hold;
   end

   // ---------------------------------------------------------------
   // byte sender: bursts of random length with random gaps between
   // ---------------------------------------------------------------
   task automatic send_byte(req_type item);
      rsp_type     res;
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_payload <= item;
      // transaction completes on the first edge without stall
      do @(posedge clock); while (req_stall);
      if (scan_byte(item, res))
         caps_expected.push_back(res);
      items_sent++;
   endtask

   task automatic send_bytes(octet_queue_type msg, bit mark_first, bit mark_last);
      req_type item;
      for (int i = 0; i < msg.size(); i++) begin
         item.data_byte  = msg[i];
         item.first_byte = mark_first && (i == 0);
         item.last_byte  = mark_last && (i == msg.size() - 1);
         send_byte(item);
      end
   endtask

   // valid low, every owed result in, then a margin for the block to settle
   task automatic wait_idle();
      req_valid  <= 1'b0;
      burst_left = 0;
      while (caps_expected.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // register access
   // ---------------------------------------------------------------
   task automatic csr_write(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_check(csr_index_type idx, logic [CSR_DATA_W-1:0] want);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== want)
         report_error($sformatf("register %s read: expected %0h got %0h",
            idx.name(), want, csr_prdata));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(logic [2:0] vsel, logic pps);
      wait_idle();
      csr_write(REG_VOLTAGE_SELECT, {29'd0, vsel});
      cfg_vsel = vsel;
      csr_write(REG_PPS_SUPPORTED, {31'd0, pps});
      cfg_pps = pps;
      csr_check(REG_VOLTAGE_SELECT, {29'd0, vsel});
      csr_check(REG_PPS_SUPPORTED, {31'd0, pps});
   endtask

   // ---------------------------------------------------------------
   // message building
   // ---------------------------------------------------------------

   // little-endian header, count in bits 14:12, all other bits random
   function automatic octet_queue_type caps_header(logic [2:0] count);
      octet_queue_type q;
      logic [7:0]      hi;
      hi      = 8'($urandom);
      hi[6:4] = count;
      q.push_back(8'($urandom));
      q.push_back(hi);
      return q;
   endfunction

   function automatic void append_word(ref octet_queue_type q, input logic [31:0] w);
      for (int i = 0; i < 4; i++)
         q.push_back(w[8*i +: 8]);
   endfunction

   function automatic logic [31:0] fixed_pdo(logic [9:0] units, logic [9:0] cur);
      logic [31:0] w;
      w          = $urandom;
      w[31:30]   = SUPPLY_FIXED;
      w[19:10]   = units;
      w[9:0]     = cur;
      return w;
   endfunction

   function automatic logic [31:0] pps_pdo();
      logic [31:0] w;
      w        = $urandom;
      w[31:30] = SUPPLY_AUGMENTED;
      w[29:28] = AUG_PPS;
      return w;
   endfunction

   // mix of matching fixed objects, other fixed, pps, other augmented and noise
   function automatic logic [31:0] random_pdo();
      logic [31:0] w;
      logic [10:0] target;
      w = $urandom;
      case ($urandom_range(0, 6))
         0, 1, 2: begin
            target = target_for(3'($urandom_range(0, 5)));
            w[31:30] = SUPPLY_FIXED;
            w[19:10] = target[9:0];
            // current extremes now and then
            if ($urandom_range(0, 3) == 0)
               w[9:0] = $urandom_range(0, 1) ? 10'h3FF : 10'h000;
         end
         3: w[31:30] = SUPPLY_FIXED;
         4: w = pps_pdo();
         5: w[31:30] = SUPPLY_AUGMENTED;
         default: ;
      endcase
      return w;
   endfunction

   // mostly well-formed, sometimes short, over-long or continuing without a first mark
   task automatic send_random_message();
      octet_queue_type msg;
      logic [2:0]      count;
      int unsigned     nobj;
      int unsigned     cut;
      count = 3'($urandom_range(0, 7));
      nobj  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : count;
      msg   = caps_header(count);
      for (int i = 0; i < nobj; i++)
         append_word(msg, random_pdo());
      case ($urandom_range(0, 9))
         0: repeat ($urandom_range(1, 24)) msg.push_back(8'($urandom));
         1: begin
            cut = $urandom_range(1, msg.size());
            while (msg.size() > cut) void'(msg.pop_back());
         end
         default: ;
      endcase
      send_bytes(msg, $urandom_range(0, 15) != 0, 1'b1);
   endtask

   // random bytes with random first and last marks
   task automatic send_noise();
      req_type item;
      repeat ($urandom_range(1, 8)) begin
         item.data_byte  = 8'($urandom);
         item.first_byte = ($urandom_range(0, 3) == 0);
         item.last_byte  = ($urandom_range(0, 5) == 0);
         send_byte(item);
      end
   endtask

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // scan starts at offset 0 after reset even without a first mark;
   // also checks the register reset values
   task automatic test_no_first_after_reset();
      octet_queue_type msg;
      csr_check(REG_VOLTAGE_SELECT, 32'd0);
      csr_check(REG_PPS_SUPPORTED, 32'd1);
      msg = caps_header(3'd2);
      append_word(msg, fixed_pdo(10'd100, 10'h3FF));
      append_word(msg, pps_pdo());
      send_bytes(msg, 1'b0, 1'b1);
   endtask

   // first and last on the same byte: header incomplete, count zero
   task automatic test_single_byte_message();
      send_bytes('{8'hFF}, 1'b1, 1'b1);
      send_bytes('{8'h00}, 1'b1, 1'b1);
   endtask

   // after a last byte the scan carries on at the following offsets
   task automatic test_continue_after_last();
      octet_queue_type msg;
      octet_queue_type tail;
      msg = caps_header(3'd1);
      append_word(msg, fixed_pdo(10'd100, 10'd0));
      send_bytes(msg, 1'b1, 1'b1);
      append_word(tail, fixed_pdo(10'd100, 10'h155));
      send_bytes(tail, 1'b0, 1'b1);
   endtask

   // zero count is invalid; objects beyond the count are ignored
   task automatic test_count_limits();
      octet_queue_type msg;
      msg = caps_header(3'd0);
      append_word(msg, fixed_pdo(10'd100, 10'd5));
      append_word(msg, pps_pdo());
      send_bytes(msg, 1'b1, 1'b1);
      msg = caps_header(3'd1);
      append_word(msg, fixed_pdo(10'd999, 10'd3));
      append_word(msg, fixed_pdo(10'd100, 10'd77));
      append_word(msg, pps_pdo());
      send_bytes(msg, 1'b1, 1'b1);
   endtask

   // full count, then bytes past the end of the area with last beyond it
   task automatic test_past_area();
      octet_queue_type msg;
      msg = caps_header(3'd7);
      for (int i = 0; i < 7; i++)
         append_word(msg, random_pdo());
      repeat (22) msg.push_back(8'($urandom));
      send_bytes(msg, 1'b1, 1'b1);
      msg = '{8'hFF, 8'h00, 8'hA5};
      send_bytes(msg, 1'b0, 1'b1);
   endtask

   // every select code incl. unused ones, both pps settings; six fixed
   // objects in rotated order plus either a duplicate or a pps object
   task automatic test_voltage_codes();
      octet_queue_type msg;
      logic [10:0]     target;
      int unsigned     start;
      for (int code = 0; code < 8; code++) begin
         set_config(3'(code), 1'(code));
         start = $urandom_range(0, 5);
         msg   = caps_header(3'd7);
         for (int k = 0; k < 6; k++) begin
            target = target_for(3'((start + k) % 6));
            append_word(msg, fixed_pdo(target[9:0], 10'($urandom)));
         end
         // second object at the selected voltage must lose to the first
         target = target_for(3'(code));
         append_word(msg, $urandom_range(0, 1) ? fixed_pdo(target[9:0], 10'h3FF) : pps_pdo());
         send_bytes(msg, 1'b1, 1'b1);
      end
      set_config(VSEL_28V, 1'b0);
      msg = caps_header(3'd2);
      append_word(msg, pps_pdo());
      append_word(msg, fixed_pdo(10'd560, 10'h3FF));
      send_bytes(msg, 1'b1, 1'b1);
      set_config(VSEL_5V, 1'b1);
   endtask

   // bulk traffic with config changes and full drains along the way
   task automatic test_random_traffic();
      int unsigned goal;
      goal = items_sent + 850;
      while (items_sent < goal) begin
         case ($urandom_range(0, 19))
            0, 1: send_noise();
            2:    set_config(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
            3:    wait_idle();
            default: send_random_message();
         endcase
      end
   endtask

   // ---------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_no_first_after_reset();
      test_single_byte_message();
      test_continue_after_last();
      test_count_limits();
      test_past_area();
      test_voltage_codes();
      test_random_traffic();

      // drain, then a little margin for any stray result
      req_valid <= 1'b0;
      while (caps_expected.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (error_count == 0)
         $display("tb_pd_source_caps_scanner_unit passed");
      else
         $display("tb_pd_source_caps_scanner_unit failed");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #(4_000_000);
      $display("tb_pd_source_caps_scanner_unit failed");
      $finish;
   end

endmodule
